@@ src/skmj_pkg.sv @@
// shared types, constants and codes of the sorted k-mer seed merge join
// no dependencies; imported by every module of the block
package skmj_pkg;

    // list storage
    localparam int Q_DEPTH = 4096;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;
    localparam int S_DEPTH = 16384;
    localparam int S_AW    = $clog2(S_DEPTH);
    localparam int S_CW    = S_AW + 1;
    localparam int POS_W   = 24;
    localparam int HASH_W  = 64;

    // configuration
    localparam int LIM_W     = 6;
    localparam int LIMIT_CAP = 32;
    localparam int CFG_AW    = 4;

    // request codes
    localparam logic [2:0] REQ_LDQ  = 3'd0;
    localparam logic [2:0] REQ_LDS  = 3'd1;
    localparam logic [2:0] REQ_ADV  = 3'd2;
    localparam logic [2:0] REQ_CLRQ = 3'd3;
    localparam logic [2:0] REQ_CLRS = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_FWD = 2'd0;
    localparam logic [1:0] KIND_REV = 2'd1;
    localparam logic [1:0] KIND_EXH = 2'd2;

    // direction modes
    localparam logic [1:0] DIR_FWD  = 2'd0;
    localparam logic [1:0] DIR_REV  = 2'd1;
    localparam logic [1:0] DIR_BOTH = 2'd2;

    // register indexes
    localparam logic [1:0] REG_DIR = 2'd0;
    localparam logic [1:0] REG_MWC = 2'd1;
    localparam logic [1:0] REG_MSC = 2'd2;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [HASH_W-1:0] word_hash;
        logic [POS_W-1:0]  word_position;
        logic              word_reverse;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic [POS_W-1:0] seed_query_pos;
        logic [POS_W-1:0] seed_subject_pos;
        logic             list_overflow;
        logic             last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       dir_mode;
        logic [LIM_W-1:0] max_word;
        logic [LIM_W-1:0] max_seed;
    } t_cfg;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LDQ       = 4'd1,
        OP_LDS       = 4'd2,
        OP_CLRQ      = 4'd3,
        OP_CLRS      = 4'd4,
        OP_START     = 4'd5,
        OP_SKIPS_INI = 4'd6,
        OP_SKIPS     = 4'd7,
        OP_SKIPQ_INI = 4'd8,
        OP_SKIPQ     = 4'd9,
        OP_MATCH_INI = 4'd10,
        OP_SCANQ     = 4'd11,
        OP_SCANS     = 4'd12,
        OP_DECIDE    = 4'd13,
        OP_RUNF      = 4'd14,
        OP_RUNR      = 4'd15
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   put;
        logic   put_exh;
    } t_dp_cmd;

    typedef struct packed {
        logic q_avail;
        logic s_avail;
        logic s_lt;
        logic q_lt;
        logic q_in;
        logic s_in;
        logic ok_f;
        logic ok_r;
        logic pair_end;
        logic run_fwd;
        logic out_free;
        logic ovf;
    } t_dp_status;

endpackage

@@ src/skmj_ctrl.sv @@
// controller state machine of the merge join: sequences loads, the walk and seed output
// depends on skmj_pkg
module skmj_ctrl
    import skmj_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_req_type,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [17:0] {
        ST_IDLE  = 18'd1,
        ST_CHK   = 18'd2,
        ST_CMPW  = 18'd4,
        ST_CMP   = 18'd8,
        ST_SKSW  = 18'd16,
        ST_SKS   = 18'd32,
        ST_SKQW  = 18'd64,
        ST_SKQ   = 18'd128,
        ST_SCQW  = 18'd256,
        ST_SCQ   = 18'd512,
        ST_SCSW  = 18'd1024,
        ST_SCS   = 18'd2048,
        ST_DEC   = 18'd4096,
        ST_DEC2  = 18'd8192,
        ST_RUNR  = 18'd16384,
        ST_EW    = 18'd32768,
        ST_EPUT  = 18'd65536,
        ST_EXH   = 18'd131072
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd.op      = OP_NONE;
        o_cmd.put     = 1'b0;
        o_cmd.put_exh = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_req_type)
                        REQ_LDQ:  o_cmd.op = OP_LDQ;
                        REQ_LDS:  o_cmd.op = OP_LDS;
                        REQ_CLRQ: o_cmd.op = OP_CLRQ;
                        REQ_CLRS: o_cmd.op = OP_CLRS;
                        REQ_ADV:  n_state  = ST_CHK;
                        default:  o_cmd.op = OP_NONE;
                    endcase
                end
            end
            ST_CHK: begin
                if (i_status.q_avail && i_status.s_avail) begin
                    o_cmd.op = OP_START;
                    n_state  = ST_CMPW;
                end else begin
                    n_state = ST_EXH;
                end
            end
            ST_CMPW: n_state = ST_CMP;
            ST_CMP: begin
                if (i_status.s_lt) begin
                    o_cmd.op = OP_SKIPS_INI;
                    n_state  = ST_SKSW;
                end else if (i_status.q_lt) begin
                    o_cmd.op = OP_SKIPQ_INI;
                    n_state  = ST_SKQW;
                end else begin
                    o_cmd.op = OP_MATCH_INI;
                    n_state  = ST_SCQW;
                end
            end
            ST_SKSW: n_state = ST_SKS;
            ST_SKS: begin
                o_cmd.op = OP_SKIPS;
                n_state  = i_status.s_in ? ST_SKSW : ST_CHK;
            end
            ST_SKQW: n_state = ST_SKQ;
            ST_SKQ: begin
                o_cmd.op = OP_SKIPQ;
                n_state  = i_status.q_in ? ST_SKQW : ST_CHK;
            end
            ST_SCQW: n_state = ST_SCQ;
            ST_SCQ: begin
                o_cmd.op = OP_SCANQ;
                n_state  = i_status.q_in ? ST_SCQW : ST_SCSW;
            end
            ST_SCSW: n_state = ST_SCS;
            ST_SCS: begin
                o_cmd.op = OP_SCANS;
                n_state  = i_status.s_in ? ST_SCSW : ST_DEC;
            end
            ST_DEC: begin
                o_cmd.op = OP_DECIDE;
                n_state  = ST_DEC2;
            end
            ST_DEC2: begin
                if (i_status.ok_f) begin
                    o_cmd.op = OP_RUNF;
                    n_state  = ST_EW;
                end else if (i_status.ok_r) begin
                    o_cmd.op = OP_RUNR;
                    n_state  = ST_EW;
                end else begin
                    n_state = ST_CHK;
                end
            end
            ST_RUNR: begin
                o_cmd.op = OP_RUNR;
                n_state  = ST_EW;
            end
            ST_EW: n_state = ST_EPUT;
            ST_EPUT: begin
                if (i_status.out_free) begin
                    o_cmd.put = 1'b1;
                    if (!i_status.pair_end) begin
                        n_state = ST_EW;
                    end else if (i_status.run_fwd && i_status.ok_r) begin
                        n_state = ST_RUNR;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EXH: begin
                if (i_status.out_free) begin
                    o_cmd.put_exh = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

@@ src/skmj_dp.sv @@
// datapath of the merge join: list memories, cursors, group scan and output register
// depends on skmj_pkg; driven by skmj_ctrl
module skmj_dp
    import skmj_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_item,
    input  t_cfg       i_cfg,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_item  o_out_item,
    input  logic       i_out_stall
);

    // list memories
    logic [HASH_W-1:0] r_qhash_mem [Q_DEPTH];
    logic [POS_W-1:0]  r_qpos_mem  [Q_DEPTH];
    logic [HASH_W-1:0] r_shash_mem [S_DEPTH];
    logic [POS_W-1:0]  r_spos_mem  [S_DEPTH];
    logic              r_sstr_mem  [S_DEPTH];

    logic [HASH_W-1:0] r_q_rd_hash, r_s_rd_hash, r_key;
    logic [POS_W-1:0]  r_q_rd_pos, r_s_rd_pos;
    logic              r_s_rd_str;

    logic [Q_CW-1:0] r_qfill, r_qcur, r_qp, r_qbeg, r_qend;
    logic [S_CW-1:0] r_sfill, r_scur, r_sp, r_sbeg, r_mid, r_send;
    logic [S_CW-1:0] r_run_start, r_run_end;
    logic            r_ovf, r_rev_seen, r_ok_f, r_ok_r, r_run_fwd;
    logic            r_out_valid;
    t_out_item       r_out_item;

    // query memory: load port and registered read at the walk pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LDQ && r_qfill < Q_CW'(Q_DEPTH)) begin
            r_qhash_mem[r_qfill[Q_AW-1:0]] <= i_in_item.word_hash;
            r_qpos_mem[r_qfill[Q_AW-1:0]]  <= i_in_item.word_position;
        end
        r_q_rd_hash <= r_qhash_mem[r_qp[Q_AW-1:0]];
        r_q_rd_pos  <= r_qpos_mem[r_qp[Q_AW-1:0]];
    end

    // subject memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LDS && r_sfill < S_CW'(S_DEPTH)) begin
            r_shash_mem[r_sfill[S_AW-1:0]] <= i_in_item.word_hash;
            r_spos_mem[r_sfill[S_AW-1:0]]  <= i_in_item.word_position;
            r_sstr_mem[r_sfill[S_AW-1:0]]  <= i_in_item.word_reverse;
        end
        r_s_rd_hash <= r_shash_mem[r_sp[S_AW-1:0]];
        r_s_rd_pos  <= r_spos_mem[r_sp[S_AW-1:0]];
        r_s_rd_str  <= r_sstr_mem[r_sp[S_AW-1:0]];
    end

    // group membership of the entries under the pointers
    logic q_in, s_in;
    assign q_in = (r_qp < r_qfill) && (r_q_rd_hash == r_key);
    assign s_in = (r_sp < r_sfill) && (r_s_rd_hash == r_key);

    // run acceptance checks
    logic [Q_CW-1:0]     qn;
    logic [S_CW-1:0]     fn, rn;
    logic [2*LIM_W-1:0]  prod_f, prod_r;
    logic                ok_q, dir_f, dir_r, ok_f, ok_r;
    always_comb begin
        qn     = r_qend - r_qbeg;
        fn     = r_mid - r_sbeg;
        rn     = r_send - r_mid;
        prod_f = qn[LIM_W-1:0] * fn[LIM_W-1:0];
        prod_r = qn[LIM_W-1:0] * rn[LIM_W-1:0];
        ok_q   = qn <= Q_CW'(i_cfg.max_word);
        dir_f  = (i_cfg.dir_mode == DIR_FWD) || (i_cfg.dir_mode == DIR_BOTH);
        dir_r  = (i_cfg.dir_mode == DIR_REV) || (i_cfg.dir_mode == DIR_BOTH);
        ok_f   = ok_q && dir_f && (fn != '0) && (fn <= S_CW'(i_cfg.max_word))
                 && (prod_f <= (2*LIM_W)'(i_cfg.max_seed));
        ok_r   = ok_q && dir_r && (rn != '0) && (rn <= S_CW'(i_cfg.max_word))
                 && (prod_r <= (2*LIM_W)'(i_cfg.max_seed));
    end

    // pair position within the current run
    logic s_wrap, pair_end, out_free;
    assign s_wrap   = (r_sp + S_CW'(1)) == r_run_end;
    assign pair_end = s_wrap && ((r_qp + Q_CW'(1)) == r_qend);
    assign out_free = !r_out_valid || !i_out_stall;

    // fill counts, cursors and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qfill <= '0;
            r_sfill <= '0;
            r_qcur  <= '0;
            r_scur  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_LDQ: begin
                    if (r_qfill < Q_CW'(Q_DEPTH)) r_qfill <= r_qfill + Q_CW'(1);
                    else                          r_ovf   <= 1'b1;
                end
                OP_LDS: begin
                    if (r_sfill < S_CW'(S_DEPTH)) r_sfill <= r_sfill + S_CW'(1);
                    else                          r_ovf   <= 1'b1;
                end
                OP_CLRQ: begin
                    r_qfill <= '0;
                    r_qcur  <= '0;
                end
                OP_CLRS: begin
                    r_sfill <= '0;
                    r_scur  <= '0;
                end
                OP_SKIPS: if (!s_in) r_scur <= r_sp;
                OP_SKIPQ: if (!q_in) r_qcur <= r_qp;
                OP_DECIDE: begin
                    r_qcur <= r_qend;
                    r_scur <= r_send;
                end
                default: r_ovf <= r_ovf;
            endcase
        end
    end

    // walk pointers and group bounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            if (s_wrap) begin
                r_sp <= r_run_start;
                r_qp <= r_qp + Q_CW'(1);
            end else begin
                r_sp <= r_sp + S_CW'(1);
            end
        end
        case (i_cmd.op)
            OP_START: begin
                r_qp <= r_qcur;
                r_sp <= r_scur;
            end
            OP_SKIPS_INI: begin
                r_key <= r_s_rd_hash;
                r_sp  <= r_sp + S_CW'(1);
            end
            OP_SKIPS: if (s_in) r_sp <= r_sp + S_CW'(1);
            OP_SKIPQ_INI: begin
                r_key <= r_q_rd_hash;
                r_qp  <= r_qp + Q_CW'(1);
            end
            OP_SKIPQ: if (q_in) r_qp <= r_qp + Q_CW'(1);
            OP_MATCH_INI: begin
                r_key      <= r_q_rd_hash;
                r_qp       <= r_qp + Q_CW'(1);
                r_qbeg     <= r_qcur;
                r_sbeg     <= r_scur;
                r_mid      <= r_scur;
                r_rev_seen <= 1'b0;
            end
            OP_SCANQ: begin
                if (q_in) r_qp   <= r_qp + Q_CW'(1);
                else      r_qend <= r_qp;
            end
            OP_SCANS: begin
                if (s_in) begin
                    r_sp <= r_sp + S_CW'(1);
                    if (!r_rev_seen && !r_s_rd_str) r_mid      <= r_sp + S_CW'(1);
                    else                            r_rev_seen <= 1'b1;
                end else begin
                    r_send <= r_sp;
                end
            end
            OP_DECIDE: begin
                r_ok_f <= ok_f;
                r_ok_r <= ok_r;
            end
            OP_RUNF: begin
                r_qp        <= r_qbeg;
                r_sp        <= r_sbeg;
                r_run_start <= r_sbeg;
                r_run_end   <= r_mid;
                r_run_fwd   <= 1'b1;
            end
            OP_RUNR: begin
                r_qp        <= r_qbeg;
                r_sp        <= r_mid;
                r_run_start <= r_mid;
                r_run_end   <= r_send;
                r_run_fwd   <= 1'b0;
            end
            default: r_key <= r_key;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.put || i_cmd.put_exh) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_out_item.result_kind      <= r_run_fwd ? KIND_FWD : KIND_REV;
            r_out_item.seed_query_pos   <= r_q_rd_pos;
            r_out_item.seed_subject_pos <= r_s_rd_pos;
            r_out_item.list_overflow    <= r_ovf;
            r_out_item.last_of_run      <= pair_end && (!r_run_fwd || !r_ok_r);
        end else if (i_cmd.put_exh) begin
            r_out_item.result_kind      <= KIND_EXH;
            r_out_item.seed_query_pos   <= '0;
            r_out_item.seed_subject_pos <= '0;
            r_out_item.list_overflow    <= r_ovf;
            r_out_item.last_of_run      <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // status to the controller
    always_comb begin
        o_status.q_avail  = r_qcur < r_qfill;
        o_status.s_avail  = r_scur < r_sfill;
        o_status.s_lt     = r_s_rd_hash < r_q_rd_hash;
        o_status.q_lt     = r_q_rd_hash < r_s_rd_hash;
        o_status.q_in     = q_in;
        o_status.s_in     = s_in;
        o_status.ok_f     = r_ok_f;
        o_status.ok_r     = r_ok_r;
        o_status.pair_end = pair_end;
        o_status.run_fwd  = r_run_fwd;
        o_status.out_free = out_free;
        o_status.ovf      = r_ovf;
    end

endmodule

@@ src/sorted_kmer_seed_merge_join_core.sv @@
// Sorted k-mer seed merge join: top level with configuration registers.
// Input items load, clear or advance; each advance yields seed items or one
// exhausted item. Valid/stall on both channels, configuration over APB.
// Load, clear and unknown items give no result. An advance walks both
// lists through one registered read port per list: it compares the list
// heads, skips entries, scans each entry of a matched group, decides the
// group, then emits the seeds. When a list is already spent, the exhausted
// item follows the advance through the check and exhausted states. No new
// item is accepted while an advance is walking, but the block returns to
// accepting as soon as the final result is in the output register, so loads
// proceed while that result is still waiting.
// A stalled receiver holds the output register; the walk waits on it.
// Reset empties both lists, clears the overflow flag and restores
// direction_mode 2, max_word_count 8 and max_seed_count 8. No clearing pass
// is needed: entries are only read below the fill counts.
module sorted_kmer_seed_merge_join_core
    import skmj_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  t_in_item          i_in_item,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output t_out_item         o_out_item,
    input  logic              i_out_stall,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg       r_cfg;
    t_dp_cmd    cmd;
    t_dp_status status;
    logic [LIM_W-1:0] wr_lim;

    // configuration registers, limits saturate at the cap (judged on the low LIM_W bits of the write data)
    assign wr_lim = (pwdata[LIM_W-1:0] > LIM_W'(LIMIT_CAP)) ? LIM_W'(LIMIT_CAP)
                                                              : pwdata[LIM_W-1:0];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dir_mode <= DIR_BOTH;
            r_cfg.max_word <= LIM_W'(8);
            r_cfg.max_seed <= LIM_W'(8);
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_DIR: r_cfg.dir_mode <= pwdata[1:0];
                REG_MWC: r_cfg.max_word <= wr_lim;
                REG_MSC: r_cfg.max_seed <= wr_lim;
                default: r_cfg.dir_mode <= r_cfg.dir_mode;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[3:2])
            REG_DIR: prdata = {30'd0, r_cfg.dir_mode};
            REG_MWC: prdata = {26'd0, r_cfg.max_word};
            REG_MSC: prdata = {26'd0, r_cfg.max_seed};
            default: prdata = '0;
        endcase
    end

    skmj_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_item.req_type),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    skmj_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    // exhausted item carries no positions and ends its advance
    a_exh_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.result_kind == KIND_EXH) |->
        (o_out_item.last_of_run && o_out_item.seed_query_pos == '0
         && o_out_item.seed_subject_pos == '0))
        else $error("exhausted item malformed");

    // overflow flag is sticky
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(status.ovf) |-> status.ovf)
        else $error("overflow flag dropped");

    // an accepted advance blocks further input
    a_adv_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_item.req_type == REQ_ADV) |=> o_in_stall)
        else $error("advance did not start walk");

endmodule
